// ===== hw/rtl/sprite_pixel_address_generator_macros.svh =====
// ---------------------------------------------------------------------------
// Sprite pixel address generator assertion macros
// Shared property templates, clocked on i_clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SPRITE_PIXEL_ADDRESS_GENERATOR_MACROS_SVH
`define SPRITE_PIXEL_ADDRESS_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold after the antecedent, delayed by dly.
`define SPAG_ASSERT_AFTER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== hw/rtl/spag_pkg.sv =====
// ---------------------------------------------------------------------------
// Sprite pixel address generator package
// Transfer types, the sprite size tables and pipeline constants.
// ---------------------------------------------------------------------------
package spag_pkg;

    // Number of register stages from an accepted item to its result.
    localparam int unsigned Latency = 4;

    // One input transfer: attribute words, affine matrix and local position.
    typedef struct packed {
        logic [15:0]        attr_word0;
        logic [15:0]        attr_word1;
        logic [15:0]        attr_word2;
        logic signed [15:0] param_a;
        logic signed [15:0] param_b;
        logic signed [15:0] param_c;
        logic signed [15:0] param_d;
        logic [7:0]         pos_x;
        logic [7:0]         pos_y;
    } t_spag_in;

    // One result transfer.
    typedef struct packed {
        logic        visible;
        logic [15:0] byte_offset;
        logic        high_nibble;
        logic        eight_bpp;
        logic [3:0]  pal_bank;
    } t_spag_out;

    // Sprite width in pixels from shape and size; shape three is unused.
    function automatic logic [6:0] size_width(input logic [1:0] shape,
                                              input logic [1:0] size);
        logic [6:0] w;
        case ({shape, size})
            4'b00_00: w = 7'd8;
            4'b00_01: w = 7'd16;
            4'b00_10: w = 7'd32;
            4'b00_11: w = 7'd64;
            4'b01_00: w = 7'd16;
            4'b01_01: w = 7'd32;
            4'b01_10: w = 7'd32;
            4'b01_11: w = 7'd64;
            4'b10_00: w = 7'd8;
            4'b10_01: w = 7'd8;
            4'b10_10: w = 7'd16;
            4'b10_11: w = 7'd32;
            default:  w = 7'd0;
        endcase
        return w;
    endfunction

    // Sprite height in pixels from shape and size; shape three is unused.
    function automatic logic [6:0] size_height(input logic [1:0] shape,
                                               input logic [1:0] size);
        logic [6:0] h;
        case ({shape, size})
            4'b00_00: h = 7'd8;
            4'b00_01: h = 7'd16;
            4'b00_10: h = 7'd32;
            4'b00_11: h = 7'd64;
            4'b01_00: h = 7'd8;
            4'b01_01: h = 7'd8;
            4'b01_10: h = 7'd16;
            4'b01_11: h = 7'd32;
            4'b10_00: h = 7'd16;
            4'b10_01: h = 7'd32;
            4'b10_10: h = 7'd32;
            4'b10_11: h = 7'd64;
            default:  h = 7'd0;
        endcase
        return h;
    endfunction

endpackage

// ===== hw/rtl/sprite_pixel_address_generator.sv =====
// ---------------------------------------------------------------------------
// Sprite pixel address generator
// Maps one sprite pixel to its texel byte offset in object tile memory,
// through the affine matrix or the flips, in a four stage pipeline.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------
//  item      in         start high, busy low      i_item (t_spag_in)
//  result    out        o_result_valid, 1 cycle   o_result (t_spag_out)
//
// One item enters per clock; its result is registered at the end of the last stage.
// The stages are attribute decode, the four affine multipliers,
// texel sum and range check, and tile address assembly.
// busy is always low and the receiver cannot hold results off: nothing stalls.
// Synchronous active-low reset clears the stage valid bits only.
//
module sprite_pixel_address_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spag_pkg::t_spag_in i_item,
    output logic               o_result_valid,
    output spag_pkg::t_spag_out o_result
);

    // Stage 1 payload: decoded attributes and centered position.
    typedef struct packed {
        logic               vis;
        logic               affine;
        logic               bpp8;
        logic [3:0]         bank;
        logic [9:0]         tile_id;
        logic [6:0]         w;
        logic [6:0]         h;
        logic signed [9:0]  dx;
        logic signed [9:0]  dy;
        logic [5:0]         tx;
        logic [5:0]         ty;
        logic signed [15:0] pa;
        logic signed [15:0] pb;
        logic signed [15:0] pc;
        logic signed [15:0] pd;
    } t_stage1;

    // Stage 2 payload: the four matrix products.
    typedef struct packed {
        logic               vis;
        logic               affine;
        logic               bpp8;
        logic [3:0]         bank;
        logic [9:0]         tile_id;
        logic [6:0]         w;
        logic [6:0]         h;
        logic [5:0]         tx;
        logic [5:0]         ty;
        logic signed [25:0] prod_ax;
        logic signed [25:0] prod_by;
        logic signed [25:0] prod_cx;
        logic signed [25:0] prod_dy;
    } t_stage2;

    // Stage 3 payload: final texel coordinates.
    typedef struct packed {
        logic       vis;
        logic       bpp8;
        logic [3:0] bank;
        logic [9:0] tile_id;
        logic [6:0] w;
        logic [5:0] tx;
        logic [5:0] ty;
    } t_stage3;

    logic                r_v1, r_v2, r_v3, r_v4;
    t_stage1             r_s1, n_s1;
    t_stage2             r_s2, n_s2;
    t_stage3             r_s3, n_s3;
    spag_pkg::t_spag_out r_out, n_out;

    logic                accept;
    logic [1:0]          shape;
    logic [1:0]          size;
    logic                dbl;
    logic                disabled;
    logic [7:0]          sw;
    logic [7:0]          sh;
    logic [5:0]          flip_x;
    logic [5:0]          flip_y;
    logic signed [26:0]  sum_x;
    logic signed [26:0]  sum_y;
    logic signed [19:0]  fx;
    logic signed [19:0]  fy;
    logic                texel_in;
    logic [7:0]          row_term;
    logic [3:0]          col_term;
    logic [10:0]         tile;
    logic [5:0]          in_tile;

    // The pipeline takes an item every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: decode shape, size and mode bits; center the position.
    always_comb begin
        shape    = i_item.attr_word0[15:14];
        size     = i_item.attr_word1[15:14];
        n_s1.w   = spag_pkg::size_width(shape, size);
        n_s1.h   = spag_pkg::size_height(shape, size);
        n_s1.affine = i_item.attr_word0[8];
        dbl      = i_item.attr_word0[8] && i_item.attr_word0[9];
        disabled = (!i_item.attr_word0[8] && i_item.attr_word0[9])
                   || (n_s1.w == 7'd0) || (n_s1.h == 7'd0);
        sw       = dbl ? {n_s1.w, 1'b0} : {1'b0, n_s1.w};
        sh       = dbl ? {n_s1.h, 1'b0} : {1'b0, n_s1.h};
        n_s1.vis = !disabled && (i_item.pos_x < sw) && (i_item.pos_y < sh);
        n_s1.bpp8    = i_item.attr_word0[13];
        n_s1.bank    = i_item.attr_word2[15:12];
        n_s1.tile_id = i_item.attr_word2[9:0];
        n_s1.dx  = $signed({2'b00, i_item.pos_x}) - $signed({3'b000, sw[7:1]});
        n_s1.dy  = $signed({2'b00, i_item.pos_y}) - $signed({3'b000, sh[7:1]});
        // Flipped coordinates modulo 64; only meaningful when the pixel is inside.
        flip_x   = n_s1.w[5:0] - 6'd1 - i_item.pos_x[5:0];
        flip_y   = n_s1.h[5:0] - 6'd1 - i_item.pos_y[5:0];
        n_s1.tx  = (!i_item.attr_word0[8] && i_item.attr_word1[12])
                   ? flip_x : i_item.pos_x[5:0];
        n_s1.ty  = (!i_item.attr_word0[8] && i_item.attr_word1[13])
                   ? flip_y : i_item.pos_y[5:0];
        n_s1.pa  = i_item.param_a;
        n_s1.pb  = i_item.param_b;
        n_s1.pc  = i_item.param_c;
        n_s1.pd  = i_item.param_d;
    end

    // Stage 2: one multiplier per matrix element.
    always_comb begin
        n_s2.vis     = r_s1.vis;
        n_s2.affine  = r_s1.affine;
        n_s2.bpp8    = r_s1.bpp8;
        n_s2.bank    = r_s1.bank;
        n_s2.tile_id = r_s1.tile_id;
        n_s2.w       = r_s1.w;
        n_s2.h       = r_s1.h;
        n_s2.tx      = r_s1.tx;
        n_s2.ty      = r_s1.ty;
        n_s2.prod_ax = r_s1.pa * r_s1.dx;
        n_s2.prod_by = r_s1.pb * r_s1.dy;
        n_s2.prod_cx = r_s1.pc * r_s1.dx;
        n_s2.prod_dy = r_s1.pd * r_s1.dy;
    end

    // Stage 3: sum, floor shift, recenter and reject texels off the sprite.
    always_comb begin
        sum_x    = 27'(r_s2.prod_ax) + 27'(r_s2.prod_by);
        sum_y    = 27'(r_s2.prod_cx) + 27'(r_s2.prod_dy);
        fx       = $signed({14'd0, r_s2.w[6:1]}) + 20'(sum_x >>> 8);
        fy       = $signed({14'd0, r_s2.h[6:1]}) + 20'(sum_y >>> 8);
        texel_in = !fx[19] && !fy[19]
                   && (fx[18:0] < {12'd0, r_s2.w})
                   && (fy[18:0] < {12'd0, r_s2.h});
        n_s3.vis     = r_s2.vis && (!r_s2.affine || texel_in);
        n_s3.bpp8    = r_s2.bpp8;
        n_s3.bank    = r_s2.bank;
        n_s3.tile_id = r_s2.tile_id;
        n_s3.w       = r_s2.w;
        n_s3.tx      = r_s2.affine ? fx[5:0] : r_s2.tx;
        n_s3.ty      = r_s2.affine ? fy[5:0] : r_s2.ty;
    end

    // Stage 4: tile number and byte offset, one-dimensional tile mapping.
    always_comb begin
        row_term = {1'b0, 7'(r_s3.ty[5:3] * r_s3.w[6:3])};
        if (r_s3.bpp8) begin
            row_term = {row_term[6:0], 1'b0};
            col_term = {r_s3.tx[5:3], 1'b0};
            in_tile  = {r_s3.ty[2:0], r_s3.tx[2:0]};
        end else begin
            col_term = {1'b0, r_s3.tx[5:3]};
            in_tile  = {1'b0, r_s3.ty[2:0], r_s3.tx[2:1]};
        end
        tile = {1'b0, r_s3.tile_id} + {3'd0, row_term} + {7'd0, col_term};
        n_out.visible      = r_s3.vis;
        n_out.byte_offset  = r_s3.vis ? ({tile, 5'd0} + {10'd0, in_tile})
                                      : 16'd0;
        n_out.high_nibble  = r_s3.vis && !r_s3.bpp8 && r_s3.tx[0];
        n_out.eight_bpp    = r_s3.bpp8;
        n_out.pal_bank     = r_s3.bank;
    end

    // Valid bits travel with the payload; reset clears only the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload registers load every cycle.
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_out <= n_out;
    end

    assign o_result_valid = r_v4;
    assign o_result       = r_out;

    // Checks on the pipeline.
    `include "sprite_pixel_address_generator_macros.svh"

    `SPAG_ASSERT_AFTER(a_latency, accept, 4, o_result_valid, "accepted item gave no result")
    `SPAG_ASSERT_AFTER(a_no_phantom, !accept, 4, !o_result_valid, "result without an item")
    `SPAG_ASSERT_NOW(a_hidden_zero, o_result_valid && !o_result.visible, (o_result.byte_offset == 16'd0) && !o_result.high_nibble, "hidden texel has an address")
    `SPAG_ASSERT_NOW(a_bpp8_nibble, o_result_valid && o_result.eight_bpp, !o_result.high_nibble, "nibble select in 8bpp mode")

endmodule

// ===== bench/sprite_pixel_address_generator_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sprite pixel address generator testbench
// Drives sprite pixels through the command port with random idle bursts,
// predicts each texel fetch on transfer and checks every result in order.
// ---------------------------------------------------------------------------
module sprite_pixel_address_generator_tb;

    // Attribute bit positions.
    localparam int AffineBit     = 8;
    localparam int DoubleOffBit  = 9;
    localparam int HflipBit      = 12;
    localparam int Bpp8Bit       = 13;
    localparam int VflipBit      = 13;
    localparam logic [1:0] ShapeUnused = 2'd3;
    localparam int BytesPerTile  = 32;

    // Random part size, and the number of last items sent with no idling.
    localparam int RandomPixels  = 1125;
    localparam int QuietTail     = 100;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    spag_pkg::t_spag_in  i_item = '0;
    logic                o_result_valid;
    spag_pkg::t_spag_out o_result;

    spag_pkg::t_spag_in  sprite_pixels_q[$];
    spag_pkg::t_spag_out fetch_results_q[$];
    int        n_total = 0;
    int        n_accepted = 0;
    int        n_errors = 0;
    int        gap_left = 0;

    sprite_pixel_address_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // Sprite width and height in pixels; shape three has no size.
    function automatic void sprite_dims(input logic [1:0] shape, input logic [1:0] sz,
                                        output int w, output int h);
        case (shape)
            2'd0: begin
                w = 8 << sz;
                h = 8 << sz;
            end
            2'd1: begin
                case (sz)
                    2'd0: begin w = 16; h = 8;  end
                    2'd1: begin w = 32; h = 8;  end
                    2'd2: begin w = 32; h = 16; end
                    default: begin w = 64; h = 32; end
                endcase
            end
            2'd2: begin
                case (sz)
                    2'd0: begin w = 8;  h = 16; end
                    2'd1: begin w = 8;  h = 32; end
                    2'd2: begin w = 16; h = 32; end
                    default: begin w = 32; h = 64; end
                endcase
            end
            default: begin
                w = 0;
                h = 0;
            end
        endcase
    endfunction

    // Expected texel fetch for one sprite pixel.
    function automatic spag_pkg::t_spag_out predict_texel_fetch(input spag_pkg::t_spag_in it);
        spag_pkg::t_spag_out r;
        int   w, h, sw, sh, dx, dy, fx, fy, tx, ty, k, tile, offs;
        logic affine, dbl, disabled, hflip, vflip, bpp8, vis;
        sprite_dims(it.attr_word0[15:14], it.attr_word1[15:14], w, h);
        affine   = it.attr_word0[AffineBit];
        dbl      = affine && it.attr_word0[DoubleOffBit];
        disabled = (!affine && it.attr_word0[DoubleOffBit]) || w == 0 || h == 0;
        hflip    = !affine && it.attr_word1[HflipBit];
        vflip    = !affine && it.attr_word1[VflipBit];
        bpp8     = it.attr_word0[Bpp8Bit];
        sw = dbl ? 2 * w : w;
        sh = dbl ? 2 * h : h;
        vis = !disabled && int'(it.pos_x) < sw && int'(it.pos_y) < sh;
        tx = 0;
        ty = 0;

        // Map the screen position to a texel.
        if (vis) begin
            if (affine) begin
                dx = int'(it.pos_x) - sw / 2;
                dy = int'(it.pos_y) - sh / 2;
                fx = w / 2 + ((int'($signed(it.param_a)) * dx
                             + int'($signed(it.param_b)) * dy) >>> 8);
                fy = h / 2 + ((int'($signed(it.param_c)) * dx
                             + int'($signed(it.param_d)) * dy) >>> 8);
                if (fx < 0 || fx >= w || fy < 0 || fy >= h) begin
                    vis = 1'b0;
                end else begin
                    tx = fx;
                    ty = fy;
                end
            end else begin
                tx = hflip ? w - 1 - int'(it.pos_x) : int'(it.pos_x);
                ty = vflip ? h - 1 - int'(it.pos_y) : int'(it.pos_y);
            end
        end

        // Tile address assembly with one-dimensional tile mapping.
        offs = 0;
        if (vis) begin
            k = bpp8 ? 2 : 1;
            tile = (int'(it.attr_word2[9:0]) + (ty / 8) * (w / 8) * k + (tx / 8) * k)
                   & 16'hFFFF;
            offs = tile * BytesPerTile
                   + (bpp8 ? (ty % 8) * 8 + tx % 8 : (ty % 8) * 4 + (tx % 8) / 2);
        end
        r.visible      = vis;
        r.byte_offset  = offs[15:0];
        r.high_nibble  = vis && !bpp8 && tx[0];
        r.eight_bpp    = bpp8;
        r.pal_bank     = it.attr_word2[15:12];
        return r;
    endfunction

    function automatic spag_pkg::t_spag_in make_pixel(input logic [15:0] a0,
                                            input logic [15:0] a1,
                                            input logic [15:0] a2, input logic [15:0] pa,
                                            input logic [15:0] pb, input logic [15:0] pc,
                                            input logic [15:0] pd, input logic [7:0] px,
                                            input logic [7:0] py);
        spag_pkg::t_spag_in it;
        it.attr_word0 = a0;
        it.attr_word1 = a1;
        it.attr_word2 = a2;
        it.param_a    = pa;
        it.param_b    = pb;
        it.param_c    = pc;
        it.param_d    = pd;
        it.pos_x      = px;
        it.pos_y      = py;
        return it;
    endfunction

    // Mostly well-formed sprites with positions inside the box and moderate
    // matrices; the rest is fully random noise.
    function automatic spag_pkg::t_spag_in random_sprite_pixel();
        spag_pkg::t_spag_in it;
        logic [1:0] shape;
        logic       affine;
        int         w, h, sw, sh;
        it = {$urandom, $urandom, $urandom, $urandom};
        shape = ($urandom_range(0, 15) == 0) ? ShapeUnused : 2'($urandom_range(0, 2));
        it.attr_word0[15:14] = shape;
        affine = 1'($urandom_range(0, 1));
        it.attr_word0[AffineBit] = affine;
        it.attr_word0[DoubleOffBit] = affine ? 1'($urandom_range(0, 1))
                                             : ($urandom_range(0, 9) == 0);
        if (affine && $urandom_range(0, 4) != 0) begin
            it.param_a = 16'(int'($urandom_range(64, 512)) * ($urandom_range(0, 1) ? 1 : -1));
            it.param_b = 16'(int'($urandom_range(0, 256)) - 128);
            it.param_c = 16'(int'($urandom_range(0, 256)) - 128);
            it.param_d = 16'(int'($urandom_range(64, 512)) * ($urandom_range(0, 1) ? 1 : -1));
        end
        sprite_dims(shape, it.attr_word1[15:14], w, h);
        sw = (affine && it.attr_word0[DoubleOffBit]) ? 2 * w : w;
        sh = (affine && it.attr_word0[DoubleOffBit]) ? 2 * h : h;
        if (sw != 0 && $urandom_range(0, 4) != 0) begin
            it.pos_x = 8'($urandom_range(0, sw - 1));
            it.pos_y = 8'($urandom_range(0, sh - 1));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $error("%s mismatch: expected %h, actual %h", field, want, got);
        n_errors++;
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Driver: presents the next pixel, predicts on every transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                fetch_results_q.push_back(predict_texel_fetch(i_item));
                n_accepted++;
            end
            if (!(start && busy)) begin
                if (gap_left == 0 && sprite_pixels_q.size() > QuietTail
                        && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 8);
                end
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (sprite_pixels_q.size() != 0) begin
                    i_item <= sprite_pixels_q.pop_front();
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        spag_pkg::t_spag_out want;
        if (i_rst_n && o_result_valid) begin
            if (fetch_results_q.size() == 0) begin
                $error("result transfer with no pending prediction");
                n_errors++;
            end else begin
                want = fetch_results_q.pop_front();
                if (o_result.visible !== want.visible)
                    report_mismatch("visible", 16'(want.visible), 16'(o_result.visible));
                if (o_result.byte_offset !== want.byte_offset)
                    report_mismatch("byte_offset", want.byte_offset, o_result.byte_offset);
                if (o_result.high_nibble !== want.high_nibble)
                    report_mismatch("high_nibble", 16'(want.high_nibble),
                                    16'(o_result.high_nibble));
                if (o_result.eight_bpp !== want.eight_bpp)
                    report_mismatch("eight_bpp", 16'(want.eight_bpp), 16'(o_result.eight_bpp));
                if (o_result.pal_bank !== want.pal_bank)
                    report_mismatch("pal_bank", 16'(want.pal_bank), 16'(o_result.pal_bank));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int w, h;

        // Every shape and size at the far corner, flips and depth varied.
        for (int s = 0; s < 4; s++) begin
            for (int z = 0; z < 4; z++) begin
                sprite_dims(2'(s), 2'(z), w, h);
                sprite_pixels_q.push_back(make_pixel(
                    16'(s << 14) | ((s + z) % 2 == 1 ? 16'h2000 : 16'h0000),
                    16'(z << 14) | 16'(((s + z) % 4) << 12),
                    16'hF3FF ^ 16'(z << 12), 16'h0100, 16'h0000, 16'h0000, 16'h0100,
                    8'(w == 0 ? 0 : w - 1), 8'(h == 0 ? 0 : h - 1)));
            end
        end
        sprite_pixels_q.push_back('0);
        sprite_pixels_q.push_back('1);
        // Disabled plain sprite, and a position just outside the box.
        sprite_pixels_q.push_back(make_pixel(16'h0200, 16'h0000, 16'h1005, 16'h0000,
                                             16'h0000, 16'h0000, 16'h0000, 8'd3, 8'd3));
        sprite_pixels_q.push_back(make_pixel(16'h0000, 16'h0000, 16'h2001, 16'h0000,
                                             16'h0000, 16'h0000, 16'h0000, 8'd8, 8'd2));
        // Affine identity left of the centre, and double size at corner and near the centre.
        sprite_pixels_q.push_back(make_pixel(16'h4100, 16'h4000, 16'h3010, 16'h0100,
                                             16'h0000, 16'h0000, 16'h0100, 8'd8, 8'd4));
        sprite_pixels_q.push_back(make_pixel(16'h0300, 16'h4000, 16'h4020, 16'h0100,
                                             16'h0000, 16'h0000, 16'h0100, 8'd0, 8'd0));
        sprite_pixels_q.push_back(make_pixel(16'h2300, 16'h4000, 16'h5020, 16'h0100,
                                             16'h0000, 16'h0000, 16'h0100, 8'd16, 8'd17));
        // Negative fractional terms that round toward minus infinity.
        sprite_pixels_q.push_back(make_pixel(16'h0100, 16'h8000, 16'h6007, 16'hFFFF,
                                             16'hFF80, 16'h0080, 16'h0100, 8'd5, 8'd19));
        // Matrix extremes.
        sprite_pixels_q.push_back(make_pixel(16'h0100, 16'hC000, 16'h7000, 16'h8000,
                                             16'h7FFF, 16'h7FFF, 16'h8000, 8'd32, 8'd33));

        for (int i = 0; i < RandomPixels; i++)
            sprite_pixels_q.push_back(random_sprite_pixel());
        n_total = sprite_pixels_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_accepted == n_total && fetch_results_q.size() == 0))
            @(posedge i_clk);
        repeat (2 * spag_pkg::Latency + 4) @(posedge i_clk);

        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
